### sv/gpio_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpio_pkg;

    localparam int PIN_COUNT_DEF = 16;
    localparam int PORT_WIDTH    = 16;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0] REG_MODE     = 4'd0;
    localparam logic [3:0] REG_OUTTYPE  = 4'd1;
    localparam logic [3:0] REG_SPEED    = 4'd2;
    localparam logic [3:0] REG_PULL     = 4'd3;
    localparam logic [3:0] REG_INDATA   = 4'd4;
    localparam logic [3:0] REG_OUTDATA  = 4'd5;
    localparam logic [3:0] REG_SETRESET = 4'd6;
    localparam logic [3:0] REG_LOCK     = 4'd7;
    localparam logic [3:0] REG_ALTLOW   = 4'd8;
    localparam logic [3:0] REG_ALTHIGH  = 4'd9;

    localparam int KEY_BIT = 16;

    typedef struct packed {
        logic        command;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } req_t;

    typedef struct packed {
        logic        en;
        logic        key;
        logic [15:0] bits;
    } lock_wr_t;

    typedef struct packed {
        logic        active;
        logic        active_next;
        logic [15:0] mask;
    } lock_status_t;

    // spread each pin bit over a 2-bit field
    function automatic logic [31:0] widen2(input logic [15:0] m);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            r[2*i +: 2] = {2{m[i]}};
        end
        return r;
    endfunction

    // spread each of eight pin bits over a 4-bit field
    function automatic logic [31:0] widen4(input logic [7:0] m);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[4*i +: 4] = {4{m[i]}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/gpio_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gpio_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;

    modport source (output valid, output command, output reg_index, output write_data,
                    output pin_levels, input ready);
    modport sink   (input valid, input command, input reg_index, input write_data,
                    input pin_levels, output ready);
endinterface

`default_nettype wire

### sv/gpio_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gpio_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic        lock_engaged;

    modport source (output valid, output read_data, output pin_drive,
                    output lock_engaged, input ready);
    modport sink   (input valid, input read_data, input pin_drive,
                    input lock_engaged, output ready);
endinterface

`default_nettype wire

### sv/gpio_lock.sv
`timescale 1ns / 1ps
`default_nettype none

module gpio_lock
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire gpio_pkg::lock_wr_t    wr,
    output gpio_pkg::lock_status_t     status
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        active_reg;
    logic        active_next;
    logic [15:0] mask_reg;
    logic [15:0] mask_next;
    logic        same;

    assign same = (wr.bits == mask_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        active_next = active_reg;
        mask_next   = mask_reg;
        if (wr.en && !active_reg)
        begin
            mask_next  = wr.bits;
            phase_next = wr.key ? PH_ONE : PH_IDLE;
            unique case (phase_reg)
                PH_ONE:
                begin
                    if (!wr.key && same)
                    begin
                        phase_next = PH_TWO;
                    end
                end
                PH_TWO:
                begin
                    if (wr.key && same)
                    begin
                        phase_next  = PH_IDLE;
                        active_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = wr.key ? PH_ONE : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            active_reg <= 1'b0;
            mask_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            mask_reg   <= mask_next;
        end
    end

    assign status.active      = active_reg;
    assign status.active_next = active_next;
    assign status.mask        = mask_reg;

endmodule

`default_nettype wire

### sv/gpio_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

module gpio_regfile
#(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire gpio_pkg::req_t req,
    output logic [31:0]        read_data,
    output logic [15:0]        pin_drive,
    output logic               lock_engaged
);

    localparam logic [32:0] PRESENT_WIDE = (33'd1 << PIN_COUNT) - 33'd1;
    localparam logic [15:0] PRESENT      = PRESENT_WIDE[15:0];

    logic [31:0] mode_reg,    mode_next;
    logic [15:0] otype_reg,   otype_next;
    logic [31:0] speed_reg,   speed_next;
    logic [31:0] pull_reg,    pull_next;
    logic [31:0] altlo_reg,   altlo_next;
    logic [31:0] althi_reg,   althi_next;
    logic [15:0] levels_reg,  levels_next;

    gpio_pkg::lock_wr_t     lock_wr;
    gpio_pkg::lock_status_t lock_st;

    logic [15:0] sample;
    logic [15:0] frozen;
    logic [15:0] open1;
    logic [31:0] open2;
    logic [31:0] open4_lo;
    logic [31:0] open4_hi;
    logic        wr_en;

    assign wr_en    = en && (req.command == gpio_pkg::CMD_WRITE);
    assign sample   = req.pin_levels & PRESENT;
    assign frozen   = lock_st.active ? (lock_st.mask & PRESENT) : '0;
    assign open1    = PRESENT & ~frozen;
    assign open2    = gpio_pkg::widen2(PRESENT) & ~gpio_pkg::widen2(frozen);
    assign open4_lo = gpio_pkg::widen4(PRESENT[7:0]) & ~gpio_pkg::widen4(frozen[7:0]);
    assign open4_hi = gpio_pkg::widen4(PRESENT[15:8]) & ~gpio_pkg::widen4(frozen[15:8]);

    assign lock_wr.en   = wr_en && (req.reg_index == gpio_pkg::REG_LOCK);
    assign lock_wr.key  = req.write_data[gpio_pkg::KEY_BIT];
    assign lock_wr.bits = req.write_data[15:0] & PRESENT;

    gpio_lock u_lock
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (lock_wr),
        .status (lock_st)
    );

    always_comb
    begin
        mode_next   = mode_reg;
        otype_next  = otype_reg;
        speed_next  = speed_reg;
        pull_next   = pull_reg;
        altlo_next  = altlo_reg;
        althi_next  = althi_reg;
        levels_next = levels_reg;
        if (wr_en)
        begin
            unique case (req.reg_index)
                gpio_pkg::REG_MODE:
                    mode_next = (mode_reg & ~open2) | (req.write_data & open2);
                gpio_pkg::REG_OUTTYPE:
                    otype_next = (otype_reg & ~open1) | (req.write_data[15:0] & open1);
                gpio_pkg::REG_SPEED:
                    speed_next = (speed_reg & ~open2) | (req.write_data & open2);
                gpio_pkg::REG_PULL:
                    pull_next = (pull_reg & ~open2) | (req.write_data & open2);
                gpio_pkg::REG_OUTDATA:
                    levels_next = req.write_data[15:0] & PRESENT;
                gpio_pkg::REG_SETRESET:
                    levels_next = ((levels_reg & ~req.write_data[31:16])
                                  | req.write_data[15:0]) & PRESENT;
                gpio_pkg::REG_ALTLOW:
                    altlo_next = (altlo_reg & ~open4_lo) | (req.write_data & open4_lo);
                gpio_pkg::REG_ALTHIGH:
                    althi_next = (althi_reg & ~open4_hi) | (req.write_data & open4_hi);
                default:
                    levels_next = levels_reg;
            endcase
        end
    end

    always_comb
    begin
        read_data = '0;
        if (req.command == gpio_pkg::CMD_READ)
        begin
            unique case (req.reg_index)
                gpio_pkg::REG_MODE:    read_data = mode_reg;
                gpio_pkg::REG_OUTTYPE: read_data = {16'd0, otype_reg};
                gpio_pkg::REG_SPEED:   read_data = speed_reg;
                gpio_pkg::REG_PULL:    read_data = pull_reg;
                gpio_pkg::REG_INDATA:  read_data = {16'd0, sample};
                gpio_pkg::REG_OUTDATA: read_data = {16'd0, levels_reg};
                gpio_pkg::REG_LOCK:    read_data = {15'd0, lock_st.active, lock_st.mask};
                gpio_pkg::REG_ALTLOW:  read_data = altlo_reg;
                gpio_pkg::REG_ALTHIGH: read_data = althi_reg;
                default:               read_data = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            otype_reg  <= '0;
            speed_reg  <= '0;
            pull_reg   <= '0;
            altlo_reg  <= '0;
            althi_reg  <= '0;
            levels_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            otype_reg  <= otype_next;
            speed_reg  <= speed_next;
            pull_reg   <= pull_next;
            altlo_reg  <= altlo_next;
            althi_reg  <= althi_next;
            levels_reg <= levels_next;
        end
    end

    assign pin_drive    = levels_next;
    assign lock_engaged = lock_st.active_next;

endmodule

`default_nettype wire

### sv/gpio_port_register_block.sv
// Path: each request passes the input register, then the result register, where its
// response is held while stalled; a stalled response also holds the input register.
// Throughput: one request per cycle while responses are taken; a taken response frees the
// result register in the same cycle, and a stalled one lets one more request into the input register.
// Reset: asynchronous, active low; clears all port registers, the lock and its key phase.
`timescale 1ns / 1ps
`default_nettype none

module gpio_port_register_block
#(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gpio_req_if.sink   req,
    gpio_rsp_if.source rsp
);

    logic           stage_valid_reg;
    gpio_pkg::req_t stage_req_reg;
    logic           rsp_valid_reg;
    logic [31:0]    read_data_reg;
    logic [15:0]    pin_drive_reg;
    logic           lock_engaged_reg;

    logic           rsp_free;
    logic           advance;
    logic           req_fire;
    logic [31:0]    read_data_next;
    logic [15:0]    pin_drive_next;
    logic           lock_engaged_next;

    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign advance   = stage_valid_reg && rsp_free;
    assign req.ready = !stage_valid_reg || rsp_free;
    assign req_fire  = req.valid && req.ready;

    gpio_regfile #(.PIN_COUNT(PIN_COUNT)) u_regfile
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .req          (stage_req_reg),
        .read_data    (read_data_next),
        .pin_drive    (pin_drive_next),
        .lock_engaged (lock_engaged_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                stage_valid_reg <= req.valid;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= stage_valid_reg;
            end
        end
    end

    // hold payload until the next request or result
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stage_req_reg.command    <= req.command;
            stage_req_reg.reg_index  <= req.reg_index;
            stage_req_reg.write_data <= req.write_data;
            stage_req_reg.pin_levels <= req.pin_levels;
        end
        if (advance)
        begin
            read_data_reg    <= read_data_next;
            pin_drive_reg    <= pin_drive_next;
            lock_engaged_reg <= lock_engaged_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_data    = read_data_reg;
    assign rsp.pin_drive    = pin_drive_reg;
    assign rsp.lock_engaged = lock_engaged_reg;

endmodule

`default_nettype wire

### sv/gpio_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gpio_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic rsp_lock_engaged
);

    logic [1:0] pending_reg;
    logic       lock_seen_reg;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            lock_seen_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(req_fire) - 2'(rsp_fire);
            if (rsp_fire && rsp_lock_engaged)
            begin
                lock_seen_reg <= 1'b1;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without an outstanding request");

    a_bounded_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !req_ready || rsp_fire)
        else $error("more requests in flight than pipeline stages");

    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && lock_seen_reg |-> rsp_lock_engaged)
        else $error("lock released before reset");

endmodule

bind gpio_port_register_block gpio_checker u_gpio_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_lock_engaged (rsp.lock_engaged)
);

`default_nettype wire
